>>> rtl/core/sifr_pkg.sv
package sifr_pkg;

    localparam int MAX_PAYLOAD = 4096;
    localparam int BYTE_COUNT_W = 13;

    localparam logic [7:0] FLAG_BYTE = 8'h5c;
    localparam logic [7:0] ESC_BYTE = 8'h5d;
    localparam logic [7:0] ESC_FLAG = 8'h7c;
    localparam logic [7:0] ESC_ESC = 8'h7d;
    localparam logic [7:0] CTRL_SEQ0 = 8'h80;
    localparam logic [7:0] CTRL_SEQ1 = 8'hC0;
    localparam logic [7:0] RR_SEQ0 = 8'h01;
    localparam logic [7:0] RR_SEQ1 = 8'h11;
    localparam logic [7:0] REJ_SEQ0 = 8'h05;
    localparam logic [7:0] REJ_SEQ1 = 8'h15;

    typedef enum logic [2:0] {
        ST_HUNT = 3'd0,
        ST_FLAG = 3'd1,
        ST_ADDR = 3'd2,
        ST_CTRL = 3'd3,
        ST_DATA = 3'd4,
        ST_OVER = 3'd5
    } parse_state_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } result_kind_t;

    typedef struct packed {
        parse_state_t             parse_state;
        logic                     expected_seq;
        logic                     frame_seq;
        logic                     escape_pending;
        logic [7:0]               held_byte;
        logic                     held_valid;
        logic [7:0]               running_xor;
        logic [BYTE_COUNT_W-1:0]  byte_count;
    } rx_state_t;

    typedef struct packed {
        result_kind_t             result_kind;
        logic [7:0]               payload_byte;
        logic [7:0]               reply_control;
        logic [BYTE_COUNT_W-1:0]  payload_length;
    } rx_result_t;

endpackage

>>> rtl/core/sifr_in_if.sv
interface sifr_in_if;
    import sifr_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] line_byte;

    modport source (output valid, output line_byte, input ready);
    modport sink (input valid, input line_byte, output ready);
endinterface

>>> rtl/core/sifr_out_if.sv
interface sifr_out_if;
    import sifr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              result_kind;
    logic [7:0]              payload_byte;
    logic [7:0]              reply_control;
    logic [BYTE_COUNT_W-1:0] payload_length;

    modport source (output valid, output result_kind, output payload_byte,
                    output reply_control, output payload_length, input ready);
    modport sink (input valid, input result_kind, input payload_byte,
                  input reply_control, input payload_length, output ready);
endinterface

>>> rtl/core/sifr_step.sv
module sifr_step (
    input  sifr_pkg::rx_state_t  cur,
    input  logic [7:0]           line_byte,
    input  logic [7:0]           frame_address,
    output sifr_pkg::rx_state_t  nxt,
    output logic                 res_valid,
    output sifr_pkg::rx_result_t res
);
    import sifr_pkg::*;

    logic [7:0] ctrl_expected;
    logic [7:0] d;
    logic       have_d;

    always_comb
    begin
        nxt = cur;
        res_valid = 1'b0;
        res = '0;
        d = line_byte;
        have_d = 1'b0;
        ctrl_expected = cur.frame_seq ? CTRL_SEQ1 : CTRL_SEQ0;

        case (cur.parse_state)
            ST_FLAG:
            begin
                if (line_byte == frame_address)
                    nxt.parse_state = ST_ADDR;
                else if (line_byte == FLAG_BYTE)
                    nxt.parse_state = ST_FLAG;
                else
                    nxt.parse_state = ST_HUNT;
            end
            ST_ADDR:
            begin
                if ((line_byte == CTRL_SEQ0 && !cur.expected_seq) ||
                    (line_byte == CTRL_SEQ1 && cur.expected_seq))
                begin
                    nxt.frame_seq = cur.expected_seq;
                    nxt.parse_state = ST_CTRL;
                end
                else if (line_byte == FLAG_BYTE)
                    nxt.parse_state = ST_FLAG;
                else
                    nxt.parse_state = ST_HUNT;
            end
            ST_CTRL:
            begin
                if (line_byte == (frame_address ^ ctrl_expected))
                begin
                    nxt.escape_pending = 1'b0;
                    nxt.held_byte = '0;
                    nxt.held_valid = 1'b0;
                    nxt.running_xor = '0;
                    nxt.byte_count = '0;
                    nxt.parse_state = ST_DATA;
                end
                else if (line_byte == FLAG_BYTE)
                    nxt.parse_state = ST_FLAG;
                else
                    nxt.parse_state = ST_HUNT;
            end
            ST_DATA, ST_OVER:
            begin
                if (line_byte == FLAG_BYTE)
                begin
                    nxt.escape_pending = 1'b0;
                    nxt.held_byte = '0;
                    nxt.held_valid = 1'b0;
                    nxt.running_xor = '0;
                    nxt.byte_count = '0;
                    if (cur.parse_state == ST_DATA && !cur.held_valid)
                        nxt.parse_state = ST_FLAG;
                    else
                    begin
                        nxt.parse_state = ST_HUNT;
                        res_valid = 1'b1;
                        res.payload_length = cur.byte_count;
                        if (cur.parse_state == ST_DATA && cur.running_xor == cur.held_byte)
                        begin
                            res.result_kind = KIND_ACCEPT;
                            res.reply_control = cur.expected_seq ? RR_SEQ0 : RR_SEQ1;
                            nxt.expected_seq = ~cur.expected_seq;
                        end
                        else
                        begin
                            res.result_kind = KIND_REJECT;
                            res.reply_control = cur.frame_seq ? REJ_SEQ1 : REJ_SEQ0;
                        end
                    end
                end
                else if (cur.parse_state == ST_DATA)
                begin
                    if (cur.escape_pending)
                    begin
                        nxt.escape_pending = 1'b0;
                        if (line_byte == ESC_FLAG)
                        begin
                            d = FLAG_BYTE;
                            have_d = 1'b1;
                        end
                        else if (line_byte == ESC_ESC)
                        begin
                            d = ESC_BYTE;
                            have_d = 1'b1;
                        end
                    end
                    else if (line_byte == ESC_BYTE)
                        nxt.escape_pending = 1'b1;
                    else
                        have_d = 1'b1;

                    if (have_d)
                    begin
                        if (!cur.held_valid)
                        begin
                            nxt.held_byte = d;
                            nxt.held_valid = 1'b1;
                        end
                        else if (cur.byte_count >= BYTE_COUNT_W'(MAX_PAYLOAD))
                            nxt.parse_state = ST_OVER;
                        else
                        begin
                            res_valid = 1'b1;
                            res.result_kind = KIND_PAYLOAD;
                            res.payload_byte = cur.held_byte;
                            nxt.running_xor = cur.running_xor ^ cur.held_byte;
                            nxt.byte_count = cur.byte_count + 1'b1;
                            nxt.held_byte = d;
                        end
                    end
                end
            end
            default:
            begin
                if (line_byte == FLAG_BYTE)
                    nxt.parse_state = ST_FLAG;
                else
                    nxt.parse_state = ST_HUNT;
            end
        endcase
    end
endmodule

>>> rtl/core/stuffed_info_frame_receiver_unit.sv
// Receiver for byte-stuffed information frames.
// The in_ch channel carries one raw line byte per beat; the out_ch channel
// carries one result per beat: a destuffed payload byte, a frame accept with
// its RR reply code, or a frame reject with its REJ reply code, each with the
// payload length of the finished frame where it applies.
// The address register, written through cfg_wr_en and cfg_wr_data, resets to
// one; only write it while the block is idle: the block does not enforce this.
// A beat taken on in_ch is held in an input register, parsed from there and,
// if it causes a result, lands in the output register when the parse step
// advances, that is when the output register is empty or out_ch.ready is high.
// One byte is taken every cycle as long as out_ch keeps up; the single
// parse step between the two registers sets that rate.
// When out_ch stalls, the output register holds its beat and the input
// register, if empty, takes one more byte before in_ch.ready falls.
// Reset clears the valid bits of both registers, hunts for an opening flag
// and sets the expected sequence bit to zero.
module stuffed_info_frame_receiver_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    sifr_in_if.sink    in_ch,
    sifr_out_if.source out_ch
);
    import sifr_pkg::*;

    logic [7:0] frame_address_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    rx_state_t  st_reg;
    rx_state_t  st_next;
    logic       out_valid_reg;
    rx_result_t out_reg;
    rx_result_t res;
    logic       res_valid;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    sifr_step u_step (
        .cur           (st_reg),
        .line_byte     (in_byte_reg),
        .frame_address (frame_address_reg),
        .nxt           (st_next),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_address_reg <= 8'h01;
        else if (cfg_wr_en)
            frame_address_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            in_byte_reg <= in_ch.line_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{parse_state: ST_HUNT, default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                st_reg <= st_next;
            if (advance)
                out_valid_reg <= res_valid;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_reg <= res;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.result_kind = out_reg.result_kind;
    assign out_ch.payload_byte = out_reg.payload_byte;
    assign out_ch.reply_control = out_reg.reply_control;
    assign out_ch.payload_length = out_reg.payload_length;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> in_valid_reg)
        else $error("Input stalled with an empty input register.");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.byte_count <= BYTE_COUNT_W'(MAX_PAYLOAD))
        else $error("Payload count beyond the maximum length.");

    a_empty_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !st_reg.held_valid |-> (st_reg.byte_count == '0 && st_reg.running_xor == '0))
        else $error("Frame totals set while no byte is held.");

    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.result_kind == KIND_PAYLOAD)
            |-> (out_reg.reply_control == '0 && out_reg.payload_length == '0))
        else $error("Payload beat carries frame fields.");

    a_seq_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.expected_seq != $past(st_reg.expected_seq))
            |-> $past(advance && res_valid && res.result_kind == KIND_ACCEPT))
        else $error("Sequence bit changed without an accepted frame.");
endmodule
